FILE: rtl/core/gvft_pkg.sv
`default_nettype none
package gvft_pkg;

   localparam int TEMP_W      = 20;
   localparam int VISC_W      = 32;
   localparam int FIT_W       = 48;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VISCOSITY_MODE         = 3'd0,
      CSR_REFERENCE_VISCOSITY    = 3'd1,
      CSR_SUTHERLAND_TEMPERATURE = 3'd2,
      CSR_REFERENCE_TEMPERATURE  = 3'd3,
      CSR_FIT_CONSTANT           = 3'd4,
      CSR_FIT_LINEAR             = 3'd5,
      CSR_FIT_SQUARE             = 3'd6,
      CSR_FIT_CUBE               = 3'd7
   } csr_index_type;

   localparam logic [1:0] MODE_CONSTANT   = 2'd0;
   localparam logic [1:0] MODE_CUBIC      = 2'd1;
   localparam logic [1:0] MODE_SUTHERLAND = 2'd2;

   localparam logic [1:0]              RST_MODE       = MODE_SUTHERLAND;
   localparam logic [VISC_W-1:0]       RST_MU0        = 32'd20121062;
   localparam logic [TEMP_W-1:0]       RST_SUTH       = 20'd28262;
   localparam logic [TEMP_W-1:0]       RST_TREF       = 20'd69926;
   localparam logic signed [FIT_W-1:0] RST_FIT_CONST  = 48'sd5089749;
   localparam logic signed [FIT_W-1:0] RST_FIT_LINEAR = 48'sd3786338300;
   localparam logic signed [FIT_W-1:0] RST_FIT_SQUARE = -48'sd90211360000;
   localparam logic signed [FIT_W-1:0] RST_FIT_CUBE   = 48'sd1387792600000;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              last;
   } side_type;

   typedef struct packed {
      logic [VISC_W-1:0] viscosity;
      logic              clamped;
      logic              last_out;
   } result_type;

   typedef struct packed {
      logic [19:0] rem;
      logic [39:0] num;
   } divr_type;

   typedef struct packed {
      logic [20:0] rem;
      logic [52:0] num;
      logic [20:0] den;
   } divq_type;

   typedef struct packed {
      logic [59:0] x;
      logic [59:0] root;
      logic [39:0] ratio;
   } sqrt_type;

   function automatic divr_type divr_step(divr_type s, logic [19:0] d);
      logic [20:0] trial;
      divr_type    o;
      trial = {s.rem, s.num[39]};
      if (trial >= {1'b0, d}) begin
         o.rem = 20'(trial - {1'b0, d});
         o.num = {s.num[38:0], 1'b1};
      end else begin
         o.rem = trial[19:0];
         o.num = {s.num[38:0], 1'b0};
      end
      return o;
   endfunction

   function automatic divq_type divq_step(divq_type s);
      logic [21:0] trial;
      divq_type    o;
      trial = {s.rem, s.num[52]};
      o.den = s.den;
      if (trial >= {1'b0, s.den}) begin
         o.rem = 21'(trial - {1'b0, s.den});
         o.num = {s.num[51:0], 1'b1};
      end else begin
         o.rem = trial[20:0];
         o.num = {s.num[51:0], 1'b0};
      end
      return o;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type s, int step);
      logic [59:0] b;
      logic [60:0] sum;
      sqrt_type    o;
      b = 60'd1 << (58 - 2 * step);
      sum = {1'b0, s.root} + {1'b0, b};
      o.ratio = s.ratio;
      if ({1'b0, s.x} >= sum) begin
         o.x    = s.x - sum[59:0];
         o.root = (s.root >> 1) + b;
      end else begin
         o.x    = s.x;
         o.root = s.root >> 1;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gvft_if.sv
`default_nettype none
interface gvft_req_if import gvft_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature;
   logic              last_cell;

   modport source(output valid, temperature, last_cell, input ready);
   modport sink(input valid, temperature, last_cell, output ready);
endinterface

interface gvft_rsp_if import gvft_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VISC_W-1:0] viscosity;
   logic              clamped;
   logic              last_out;

   modport source(output valid, viscosity, clamped, last_out, input ready);
   modport sink(input valid, viscosity, clamped, last_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/gas_viscosity_from_temperature_unit.sv
// Converts a stream of cell temperatures to dynamic viscosity, one transaction per clock
// cycle while the skid register is empty. The pipeline depth is set by the Sutherland
// path: a 40-stage ratio divider, a 30-stage square root and a 53-stage viscosity-scale
// divider, each resolving one result bit per stage, followed by split wide multiplies.
// The response side has an output register and a skid register, so a stalled response
// stops the pipeline only after two results are held. Registers are to be written by
// the user only while no transaction is in flight; the block does not enforce this.
`default_nettype none
module gas_viscosity_from_temperature_unit import gvft_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gvft_req_if.sink                    req_ch,
   gvft_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LAST = 77;

   logic [1:0]              mode_ff;
   logic [VISC_W-1:0]       mu0_ff;
   logic [TEMP_W-1:0]       suth_ff;
   logic [TEMP_W-1:0]       tref_ff;
   logic signed [FIT_W-1:0] fit_a_ff;
   logic signed [FIT_W-1:0] fit_b_ff;
   logic signed [FIT_W-1:0] fit_c_ff;
   logic signed [FIT_W-1:0] fit_d_ff;
   logic [52:0]             num_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= RST_MODE;
         mu0_ff   <= RST_MU0;
         suth_ff  <= RST_SUTH;
         tref_ff  <= RST_TREF;
         fit_a_ff <= RST_FIT_CONST;
         fit_b_ff <= RST_FIT_LINEAR;
         fit_c_ff <= RST_FIT_SQUARE;
         fit_d_ff <= RST_FIT_CUBE;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VISCOSITY_MODE:         mode_ff  <= csr_wdata[1:0];
            CSR_REFERENCE_VISCOSITY:    mu0_ff   <= csr_wdata[VISC_W-1:0];
            CSR_SUTHERLAND_TEMPERATURE: suth_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_REFERENCE_TEMPERATURE:  tref_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_FIT_CONSTANT:           fit_a_ff <= csr_wdata[FIT_W-1:0];
            CSR_FIT_LINEAR:             fit_b_ff <= csr_wdata[FIT_W-1:0];
            CSR_FIT_SQUARE:             fit_c_ff <= csr_wdata[FIT_W-1:0];
            CSR_FIT_CUBE:               fit_d_ff <= csr_wdata[FIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      num_q_ff <= 53'(mu0_ff) * 53'({1'b0, tref_ff} + {1'b0, suth_ff});
   end

   logic       en;
   logic       valid_ff [0:LAST];
   side_type   side_ff  [0:LAST];
   divr_type   dr_ff    [1:40];
   divq_type   dq_ff    [1:53];
   sqrt_type   sq_ff    [41:70];
   logic [52:0] qc_ff   [54:72];

   logic [49:0] pa_ff, pb_ff, p_ff;
   logic [63:0] ll_ff, ll2_ff;
   logic [49:0] lh_ff;
   logic [52:0] hl_ff;
   logic [38:0] hh_ff, hh2_ff, hh3_ff;
   logic [53:0] mid_ff;
   logic [86:0] acc_ff;
   logic [103:0] full;
   logic [VISC_W-1:0] su_v_ff;
   logic              su_sat_ff;

   logic signed [68:0] cm1_ff;
   logic signed [48:0] ch1_ff;
   logic signed [69:0] cm2_ff;
   logic signed [48:0] ch2_ff;
   logic signed [69:0] cm3_ff;
   logic signed [48:0] ch3_ff;

   result_type fin_in, fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_ch.valid;
         for (int k = 1; k <= LAST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign full = 104'(acc_ff) + 104'({hh3_ff, 64'd0});

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{temp: req_ch.temperature, last: req_ch.last_cell};
         for (int k = 1; k <= LAST; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         dr_ff[1] <= divr_step(divr_type'{rem: '0, num: {side_ff[0].temp, 20'd0}}, tref_ff);
         for (int k = 2; k <= 40; k++) begin
            dr_ff[k] <= divr_step(dr_ff[k-1], tref_ff);
         end

         dq_ff[1] <= divq_step(divq_type'{rem: '0, num: num_q_ff,
                                          den: {1'b0, side_ff[0].temp} + {1'b0, suth_ff}});
         for (int k = 2; k <= 53; k++) begin
            dq_ff[k] <= divq_step(dq_ff[k-1]);
         end
         qc_ff[54] <= dq_ff[53].num;
         for (int k = 55; k <= 72; k++) begin
            qc_ff[k] <= qc_ff[k-1];
         end

         sq_ff[41] <= sqrt_step(sqrt_type'{x: {dr_ff[40].num, 20'd0}, root: '0,
                                           ratio: dr_ff[40].num}, 0);
         for (int k = 42; k <= 70; k++) begin
            sq_ff[k] <= sqrt_step(sq_ff[k-1], k - 41);
         end

         pa_ff  <= 50'(sq_ff[70].ratio[39:20]) * 50'(sq_ff[70].root[29:0]);
         pb_ff  <= 50'(sq_ff[70].ratio[19:0]) * 50'(sq_ff[70].root[29:0]);
         p_ff   <= pa_ff + 50'(pb_ff[49:20]);
         ll_ff  <= 64'(qc_ff[72][31:0]) * 64'(p_ff[31:0]);
         lh_ff  <= 50'(qc_ff[72][31:0]) * 50'(p_ff[49:32]);
         hl_ff  <= 53'(qc_ff[72][52:32]) * 53'(p_ff[31:0]);
         hh_ff  <= 39'(qc_ff[72][52:32]) * 39'(p_ff[49:32]);
         mid_ff <= 54'(lh_ff) + 54'(hl_ff);
         ll2_ff <= ll_ff;
         hh2_ff <= hh_ff;
         acc_ff <= 87'(ll2_ff) + 87'({mid_ff, 32'd0});
         hh3_ff <= hh2_ff;
         su_sat_ff <= |full[103:52];
         su_v_ff   <= full[51:20];

         cm1_ff <= fit_d_ff * $signed({1'b0, side_ff[70].temp});
         ch1_ff <= 49'(cm1_ff >>> 24) + 49'(fit_c_ff);
         cm2_ff <= ch1_ff * $signed({1'b0, side_ff[72].temp});
         ch2_ff <= 49'(cm2_ff >>> 24) + 49'(fit_b_ff);
         cm3_ff <= ch2_ff * $signed({1'b0, side_ff[74].temp});
         ch3_ff <= 49'(cm3_ff >>> 24) + 49'(fit_a_ff);

         fin_ff <= fin_in;
      end
   end

   always_comb begin
      fin_in.last_out  = side_ff[LAST-1].last;
      fin_in.viscosity = mu0_ff;
      fin_in.clamped   = 1'b0;
      case (mode_ff)
         MODE_CUBIC: begin
            if (ch3_ff[48]) begin
               fin_in.viscosity = '0;
               fin_in.clamped   = 1'b1;
            end else if (|ch3_ff[47:32]) begin
               fin_in.viscosity = '1;
               fin_in.clamped   = 1'b1;
            end else begin
               fin_in.viscosity = ch3_ff[31:0];
            end
         end
         MODE_SUTHERLAND: begin
            if (side_ff[LAST-1].temp == '0) begin
               fin_in.viscosity = '0;
            end else if (tref_ff == '0 || su_sat_ff) begin
               fin_in.viscosity = '1;
               fin_in.clamped   = 1'b1;
            end else begin
               fin_in.viscosity = su_v_ff;
            end
         end
         default: ;
      endcase
   end

   logic       out_v_ff, skid_v_ff, take;
   result_type out_ff, skid_ff;

   assign en   = !skid_v_ff;
   assign take = out_v_ff && rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (valid_ff[LAST]) begin
         if (!out_v_ff || take) begin
            out_ff   <= fin_ff;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= fin_ff;
            skid_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.viscosity = out_ff.viscosity;
   assign rsp_ch.clamped   = out_ff.clamped;
   assign rsp_ch.last_out  = out_ff.last_out;

endmodule
`default_nettype wire

FILE: sim/gvft_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gvft_checker import gvft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gvft_req_if                        req_mon,
   gvft_rsp_if                        rsp_mon,
   input  wire logic                  csr_wr_en,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         failures,
   output int                         outstanding
);

   logic [1:0]              mode_r;
   logic [VISC_W-1:0]       mu0_r;
   logic [TEMP_W-1:0]       suth_r;
   logic [TEMP_W-1:0]       tref_r;
   logic signed [FIT_W-1:0] fit_const_r;
   logic signed [FIT_W-1:0] fit_linear_r;
   logic signed [FIT_W-1:0] fit_square_r;
   logic signed [FIT_W-1:0] fit_cube_r;

   result_type expected_viscosity_q[$];

   function automatic result_type predict_viscosity(logic [TEMP_W-1:0] t, logic last);
      result_type          res;
      logic signed [127:0] h;
      logic signed [127:0] tw;
      logic [63:0]         r;
      logic [63:0]         x;
      logic [63:0]         s;
      logic [63:0]         b;
      logic [63:0]         q;
      logic [127:0]        p;
      logic [127:0]        wide;
      res.viscosity = mu0_r;
      res.clamped   = 1'b0;
      res.last_out  = last;
      case (mode_r)
         MODE_CUBIC: begin
            tw = 128'(t);
            h = fit_cube_r;
            h = ((h * tw) >>> 24) + fit_square_r;
            h = ((h * tw) >>> 24) + fit_linear_r;
            h = ((h * tw) >>> 24) + fit_const_r;
            if (h < 0) begin
               res.viscosity = '0;
               res.clamped   = 1'b1;
            end else if (h > 128'sd4294967295) begin
               res.viscosity = '1;
               res.clamped   = 1'b1;
            end else begin
               res.viscosity = h[31:0];
            end
         end
         MODE_SUTHERLAND: begin
            if (t == '0) begin
               res.viscosity = '0;
            end else if (tref_r == '0) begin
               res.viscosity = '1;
               res.clamped   = 1'b1;
            end else begin
               r = (64'(t) << 20) / 64'(tref_r);
               x = r << 20;
               s = '0;
               b = 64'd1 << 62;
               while (b > x) b = b >> 2;
               while (b != 0) begin
                  if (x >= s + b) begin
                     x = x - (s + b);
                     s = (s >> 1) + b;
                  end else begin
                     s = s >> 1;
                  end
                  b = b >> 2;
               end
               p = (128'(r) * 128'(s)) >> 20;
               q = (64'(mu0_r) * (64'(tref_r) + 64'(suth_r))) / (64'(t) + 64'(suth_r));
               wide = (128'(q) * p[63:0]) >> 20;
               if (wide > 128'hFFFF_FFFF) begin
                  res.viscosity = '1;
                  res.clamped   = 1'b1;
               end else begin
                  res.viscosity = wide[31:0];
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      result_type exp_r;
      int         errs;
      errs = 0;
      if (reset) begin
         mode_r       <= RST_MODE;
         mu0_r        <= RST_MU0;
         suth_r       <= RST_SUTH;
         tref_r       <= RST_TREF;
         fit_const_r  <= RST_FIT_CONST;
         fit_linear_r <= RST_FIT_LINEAR;
         fit_square_r <= RST_FIT_SQUARE;
         fit_cube_r   <= RST_FIT_CUBE;
         expected_viscosity_q.delete();
         failures     <= 0;
         outstanding  <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VISCOSITY_MODE:         mode_r       <= csr_wdata[1:0];
               CSR_REFERENCE_VISCOSITY:    mu0_r        <= csr_wdata[31:0];
               CSR_SUTHERLAND_TEMPERATURE: suth_r       <= csr_wdata[19:0];
               CSR_REFERENCE_TEMPERATURE:  tref_r       <= csr_wdata[19:0];
               CSR_FIT_CONSTANT:           fit_const_r  <= csr_wdata;
               CSR_FIT_LINEAR:             fit_linear_r <= csr_wdata;
               CSR_FIT_SQUARE:             fit_square_r <= csr_wdata;
               CSR_FIT_CUBE:               fit_cube_r   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_viscosity_q.push_back(
               predict_viscosity(req_mon.temperature, req_mon.last_cell));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_viscosity_q.size() == 0) begin
               $error("unexpected response transaction: viscosity %0d", rsp_mon.viscosity);
               errs = errs + 1;
            end else begin
               exp_r = expected_viscosity_q.pop_front();
               if (rsp_mon.viscosity !== exp_r.viscosity) begin
                  $error("viscosity: expected %0d, actual %0d",
                         exp_r.viscosity, rsp_mon.viscosity);
                  errs = errs + 1;
               end
               if (rsp_mon.clamped !== exp_r.clamped) begin
                  $error("clamped: expected %0d, actual %0d", exp_r.clamped, rsp_mon.clamped);
                  errs = errs + 1;
               end
               if (rsp_mon.last_out !== exp_r.last_out) begin
                  $error("last_out: expected %0d, actual %0d",
                         exp_r.last_out, rsp_mon.last_out);
                  errs = errs + 1;
               end
            end
         end
         failures    <= failures + errs;
         outstanding <= expected_viscosity_q.size();
      end
   end

endmodule
`default_nettype wire

FILE: sim/tb_gas_viscosity_from_temperature_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_gas_viscosity_from_temperature_unit;
   import gvft_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  quiet;
   int                    failures;
   int                    outstanding;
   int                    cycles;

   gvft_req_if req_ch ();
   gvft_rsp_if rsp_ch ();

   gas_viscosity_from_temperature_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gvft_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles = cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("gas_viscosity_from_temperature_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 18);
            rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_cell(logic [TEMP_W-1:0] t, logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.temperature <= t;
      req_ch.last_cell   <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [TEMP_W-1:0] pick_temperature();
      case ($urandom_range(0, 7))
         0, 1:    return TEMP_W'($urandom);
         2:       return TEMP_W'($urandom_range(0, 255));
         3:       return $urandom_range(0, 1) ? '1 : TEMP_W'($urandom_range(0, 1));
         default: return TEMP_W'($urandom_range(51200, 512000));
      endcase
   endfunction

   task automatic run_phase(logic [1:0] mode, logic [31:0] mu0, logic [19:0] suth,
                            logic [19:0] tref, logic [47:0] fa, logic [47:0] fb,
                            logic [47:0] fc, logic [47:0] fd, int items);
      logic [47:0] vals[8];
      vals = '{48'(mode), 48'(mu0), 48'(suth), 48'(tref), fa, fb, fc, fd};
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (90) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      for (int i = 0; i < items; i++) send_cell(pick_temperature(), $urandom_range(0, 1));
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [TEMP_W-1:0] directed[12];
      quiet              = 1'b0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_VISCOSITY_MODE;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.temperature <= '0;
      req_ch.last_cell   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{20'd0, 20'd1, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'd69926,
                   20'd28262, 20'd256, 20'd76800, 20'hAAAAA, 20'h55555, 20'd2};
      foreach (directed[i]) send_cell(directed[i], i[0]);

      run_phase(MODE_CUBIC, RST_MU0, RST_SUTH, RST_TREF, RST_FIT_CONST, RST_FIT_LINEAR,
                RST_FIT_SQUARE, RST_FIT_CUBE, 170);
      run_phase(MODE_CONSTANT, '1, '0, 20'd1, '0, '0, '0, '0, 120);
      run_phase(2'd3, '0, 20'hFFFFF, 20'hFFFFF, '1, '1, '1, '1, 100);
      run_phase(MODE_SUTHERLAND, '1, '0, 20'd1, '0, '0, '0, '0, 150);
      run_phase(MODE_SUTHERLAND, RST_MU0, RST_SUTH, '0, '0, '0, '0, '0, 100);
      run_phase(MODE_SUTHERLAND, $urandom, 20'hFFFFF, 20'hFFFFF, '0, '0, '0, '0, 150);
      run_phase(MODE_CUBIC, RST_MU0, RST_SUTH, RST_TREF, 48'h7FFF_FFFF_FFFF,
                48'h8000_0000_0000, 48'({$urandom, $urandom}), 48'h8000_0000_0000, 150);
      run_phase(MODE_CUBIC, RST_MU0, RST_SUTH, RST_TREF, 48'h8000_0000_0000,
                48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 120);
      run_phase(MODE_CUBIC, RST_MU0, RST_SUTH, RST_TREF, 48'($urandom),
                48'($signed($urandom)), 48'($signed($urandom_range(0, 65535)) - 32768),
                48'($urandom_range(0, 4095)), 150);
      run_phase(MODE_SUTHERLAND, $urandom, 20'($urandom), 20'($urandom_range(1, 1048575)),
                '0, '0, '0, '0, 170);
      quiet = 1'b1;
      run_phase(MODE_SUTHERLAND, RST_MU0, RST_SUTH, RST_TREF, RST_FIT_CONST,
                RST_FIT_LINEAR, RST_FIT_SQUARE, RST_FIT_CUBE, 300);

      do @(posedge clock); while (outstanding != 0);
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("gas_viscosity_from_temperature_unit: match");
      end else begin
         $display("gas_viscosity_from_temperature_unit: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
